### rtl/core/point_in_polygon_test_top_defines.svh
// Assertion macros for the point-in-polygon test block.
// Included by the port checker; uses the clk_i and rst_ni names of the including scope.
`ifndef POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_TOP_DEFINES_SVH

// Concurrent check on the rising clock, switched off while reset is held.
`define PIP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// A stalled request must keep the given signal unchanged.
`define PIP_ASSERT_STALL(label, vld, rdy, sig) \
  `PIP_ASSERT(label, (vld) && !(rdy) |=> $stable(sig))

`endif

### rtl/core/pip_pkg.sv
// Shared types, constants and helpers of the point-in-polygon test block.
// Used by the front, queue, back and top level; depends on nothing else.
package pip_pkg;

  localparam int CoordBits = 32;
  localparam int RayBits   = 31;
  localparam int ExtBits   = (CoordBits > RayBits + 1) ? CoordBits : RayBits + 1;
  localparam int DiffBits  = ExtBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  localparam logic [RayBits-1:0] RayReset = {RayBits{1'b1}};

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;

  typedef struct packed {
    logic edge_en;
    logic close_en;
    logic clear;
    logic last;
    logic hit;
  } job_ctl_t;

  typedef struct packed {
    coord_t   px;
    coord_t   py;
    coord_t   prev_x;
    coord_t   prev_y;
    coord_t   cur_x;
    coord_t   cur_y;
    coord_t   first_x;
    coord_t   first_y;
    job_ctl_t ctl;
  } edge_job_t;

  function automatic coord_t take_coord(logic [31:0] v);
    return coord_t'(v[CoordBits-1:0]);
  endfunction

  function automatic diff_t ext_coord(coord_t v);
    return diff_t'(v);
  endfunction

endpackage

### rtl/core/pip_if.sv
// Request channel interfaces of the point-in-polygon test block.
// Payload fields are plain logic vectors declared here; pip_pkg types are not used.
interface pip_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   vertex_x;
  logic signed [31:0]   vertex_y;
  logic signed [31:0]   point_x;
  logic signed [31:0]   point_y;
  logic                 first_vertex;
  logic                 last_vertex;

  modport source (output valid, vertex_x, vertex_y, point_x, point_y, first_vertex,
                  last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, point_x, point_y, first_vertex,
                last_vertex, output ready);
endinterface

interface pip_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic on_vertex;

  modport source (output valid, inside_res, on_vertex, input ready);
  modport sink (input valid, inside_res, on_vertex, output ready);
endinterface

### rtl/core/pip_front.sv
// Front end: accepts vertex requests, tracks polygon sequencing and the vertex hit.
// Emits one edge job per vertex into the queue; depends on pip_pkg and pip_if.
module pip_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  pip_in_if.sink              vtx_i,
  output pip_pkg::edge_job_t  job_o,
  output logic                job_valid_o,
  input  logic                job_ready_i
);
  import pip_pkg::*;

  coord_t first_x_q, first_y_q, prev_x_q, prev_y_q, held_x_q, held_y_q;
  logic   hit_q;
  coord_t vx, vy, px_n, py_n, fx_n, fy_n;
  logic   first, hit_n, push;

  always_comb begin
    vx    = take_coord(vtx_i.vertex_x);
    vy    = take_coord(vtx_i.vertex_y);
    first = vtx_i.first_vertex;
    px_n  = first ? take_coord(vtx_i.point_x) : held_x_q;
    py_n  = first ? take_coord(vtx_i.point_y) : held_y_q;
    fx_n  = first ? vx : first_x_q;
    fy_n  = first ? vy : first_y_q;
    hit_n = (!first && hit_q) || ((vx == px_n) && (vy == py_n));

    job_o.px           = px_n;
    job_o.py           = py_n;
    job_o.prev_x       = prev_x_q;
    job_o.prev_y       = prev_y_q;
    job_o.cur_x        = vx;
    job_o.cur_y        = vy;
    job_o.first_x      = fx_n;
    job_o.first_y      = fy_n;
    job_o.ctl.edge_en  = !first;
    job_o.ctl.close_en = vtx_i.last_vertex;
    job_o.ctl.clear    = first;
    job_o.ctl.last     = vtx_i.last_vertex;
    job_o.ctl.hit      = hit_n;
  end

  assign job_valid_o = vtx_i.valid;
  assign vtx_i.ready = job_ready_i;
  assign push        = vtx_i.valid && job_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      held_x_q  <= '0;
      held_y_q  <= '0;
      hit_q     <= 1'b0;
    end else if (push) begin
      first_x_q <= fx_n;
      first_y_q <= fy_n;
      prev_x_q  <= vx;
      prev_y_q  <= vy;
      held_x_q  <= px_n;
      held_y_q  <= py_n;
      hit_q     <= hit_n;
    end
  end

endmodule

### rtl/core/pip_fifo.sv
// Short queue of edge jobs between the front end and the back end.
// Entry type and depth come from pip_pkg.
module pip_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pip_pkg::edge_job_t  wr_data_i,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  output pip_pkg::edge_job_t  rd_data_o,
  output logic                rd_valid_o,
  input  logic                rd_ready_i
);
  import pip_pkg::*;

  edge_job_t         mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q;
  logic              push, pop;

  assign wr_ready_o = (count_q != (FifoAw + 1)'(FifoDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### rtl/core/pip_back.sv
// Back end: three-stage edge test pipeline (differences, products, compare and commit).
// Holds the crossing parity and the result register; depends on pip_pkg and pip_if.
module pip_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pip_pkg::edge_job_t           job_i,
  input  logic                         job_valid_i,
  output logic                         job_ready_o,
  input  logic [pip_pkg::RayBits-1:0]  ray_end_i,
  pip_out_if.source                    res_o
);
  import pip_pkg::*;

  typedef struct packed {
    diff_t dsx;
    diff_t dpy;
    diff_t dsy;
    diff_t dpx;
    diff_t dqx;
    logic  side_ne;
  } ediff_t;

  typedef struct packed {
    prod_t pa;
    prod_t pb1;
    prod_t pb2;
    logic  side_ne;
  } eprod_t;

  function automatic logic ray_side(diff_t px, diff_t py, diff_t qx, diff_t ry);
    return ((qx > px) && (ry > py)) || ((qx < px) && (ry < py));
  endfunction

  function automatic ediff_t edge_diff(diff_t px, diff_t py, diff_t qx,
                                       diff_t rx, diff_t ry, diff_t sx, diff_t sy);
    ediff_t e;
    e.dsx     = sx - rx;
    e.dpy     = py - ry;
    e.dsy     = sy - ry;
    e.dpx     = px - rx;
    e.dqx     = qx - rx;
    e.side_ne = ray_side(px, py, qx, ry) != ray_side(px, py, qx, sy);
    return e;
  endfunction

  function automatic eprod_t edge_prod(ediff_t e);
    eprod_t p;
    p.pa      = prod_t'(e.dsx) * prod_t'(e.dpy);
    p.pb1     = prod_t'(e.dsy) * prod_t'(e.dpx);
    p.pb2     = prod_t'(e.dsy) * prod_t'(e.dqx);
    p.side_ne = e.side_ne;
    return p;
  endfunction

  function automatic logic edge_cross(eprod_t p);
    prod_t a, b1, b2;
    a  = p.pa;
    b1 = p.pb1;
    b2 = p.pb2;
    return p.side_ne && ((a > b1) != (a > b2));
  endfunction

  logic     en;
  logic     s1_valid_q, s2_valid_q, out_valid_q;
  ediff_t   s1_edge_q, s1_close_q;
  eprod_t   s2_edge_q, s2_close_q;
  job_ctl_t s1_ctl_q, s2_ctl_q;
  logic     parity_q, parity_d;
  logic     inside_q, on_vertex_q;
  diff_t    px, py, qx;

  assign en          = !out_valid_q || res_o.ready;
  assign job_ready_o = en;

  assign px = ext_coord(job_i.px);
  assign py = ext_coord(job_i.py);
  assign qx = diff_t'(ray_end_i);

  assign parity_d = (!s2_ctl_q.clear && parity_q)
                  ^ (s2_ctl_q.edge_en && edge_cross(s2_edge_q))
                  ^ (s2_ctl_q.close_en && edge_cross(s2_close_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_edge_q  <= edge_diff(px, py, qx, ext_coord(job_i.prev_x), ext_coord(job_i.prev_y),
                              ext_coord(job_i.cur_x), ext_coord(job_i.cur_y));
      s1_close_q <= edge_diff(px, py, qx, ext_coord(job_i.cur_x), ext_coord(job_i.cur_y),
                              ext_coord(job_i.first_x), ext_coord(job_i.first_y));
      s1_ctl_q   <= job_i.ctl;
      s2_edge_q  <= edge_prod(s1_edge_q);
      s2_close_q <= edge_prod(s1_close_q);
      s2_ctl_q   <= s1_ctl_q;
      if (s2_valid_q && s2_ctl_q.last) begin
        inside_q    <= parity_d || s2_ctl_q.hit;
        on_vertex_q <= s2_ctl_q.hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      parity_q    <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= job_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q && s2_ctl_q.last;
      if (s2_valid_q) begin
        parity_q <= parity_d;
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.inside_res = inside_q;
  assign res_o.on_vertex  = on_vertex_q;

endmodule

### rtl/core/point_in_polygon_test_top.sv
// Ray-crossing point-in-polygon test: one vertex request per cycle, one result per polygon.
// The block accepts one vertex every clock cycle as long as results are taken; a four-entry
// queue decouples the vertex front end from the edge test back end, so up to four more
// vertices are accepted while a result waits. The rate is set by the back end, which tests
// both the edge from the previous vertex and the closing edge in parallel with six 33 by 33
// bit multipliers in a three-stage pipeline. A result passes through the queue, the difference
// and product stages and the result register. The user must write the ray end register only
// while no polygon is in flight; the block itself does not enforce this.
module point_in_polygon_test_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pip_in_if.sink                       vtx_i,
  pip_out_if.source                    res_o,
  input  logic                         ray_end_we_i,
  input  logic [pip_pkg::RayBits-1:0]  ray_end_wdata_i
);
  import pip_pkg::*;

  logic [RayBits-1:0] ray_end_q;
  edge_job_t          fr_job, q_job;
  logic               fr_valid, fr_ready, q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ray_end_q <= RayReset;
    end else if (ray_end_we_i) begin
      ray_end_q <= ray_end_wdata_i;
    end
  end

  pip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_i       (vtx_i),
    .job_o       (fr_job),
    .job_valid_o (fr_valid),
    .job_ready_i (fr_ready)
  );

  pip_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (fr_job),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .rd_data_o  (q_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready)
  );

  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .ray_end_i   (ray_end_q),
    .res_o       (res_o)
  );

endmodule

### rtl/core/pip_chk.sv
// Port checker for the point-in-polygon test top level, attached by bind.
// Uses the assertion macros of point_in_polygon_test_top_defines.svh.
`include "point_in_polygon_test_top_defines.svh"

module pip_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic inside_i,
  input logic on_vertex_i
);

  `PIP_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i)
  `PIP_ASSERT_STALL(a_out_stable, out_valid_i, out_ready_i, {inside_i, on_vertex_i})
  `PIP_ASSERT(a_vertex_inside, out_valid_i && on_vertex_i |-> inside_i)
  `PIP_ASSERT(a_reset_empty, $rose(rst_ni) |-> !out_valid_i)

endmodule

bind point_in_polygon_test_top pip_chk u_pip_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .inside_i    (res_o.inside_res),
  .on_vertex_i (res_o.on_vertex)
);
